[rtl/core/spi_cfs_pkg.sv]
// ----------------------------------------------------------------------------
// spi_cfs_pkg
// shared types and constants for the spi command frame slave
// ----------------------------------------------------------------------------
`default_nettype none

package spi_cfs_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned EventW   = 2;
    localparam int unsigned NumArgs  = 4;
    localparam int unsigned InDataW  = 16;
    localparam int unsigned OutDataW = 56;
    localparam int unsigned OutUserW = 2;

    localparam logic [ByteW-1:0] StartByteReset = 8'h00;
    localparam logic [ByteW-1:0] TxIdleByte     = 8'h00;
    localparam logic [ByteW-1:0] TxMarkerByte   = 8'hFF;

    typedef enum logic [EventW-1:0] {
        EV_RX_BYTE    = 2'd0,
        EV_DESELECT   = 2'd1,
        EV_TAKE_FRAME = 2'd2,
        EV_SET_REPLY  = 2'd3
    } event_t;

    typedef logic [ByteW-1:0] byte_t;

endpackage : spi_cfs_pkg

`default_nettype wire

[rtl/core/spi_command_frame_slave.sv]
// ----------------------------------------------------------------------------
// spi_command_frame_slave
// frame engine for an spi slave: checks request frames, serves replies
// ----------------------------------------------------------------------------
// s_ channel: one event beat each; tuser holds the event kind, tdata the
//   received byte and the host reply byte.
// m_ channel: one result beat for every event beat, in order, holding the
//   loaded transmit byte, the taken frame and the led state.
// cfg_ channel: writes the start byte, always ready; the user must write it
//   only while idle, as the block does not enforce it. A result is in the
//   output register in the cycle after its event beat is taken; one event
//   per cycle when not stalled, state update and checksum accumulation being
//   a single registered step. stall: the output register holds its beat while
//   m_tready is low; s_tready stays high as long as that register is empty
//   or being emptied, so a stalled receiver holds off at most one further beat.
// reset: phase returns to idle, led off, start byte 0x00, no result pending.
// frame and reply stores are not reset; they are always written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_command_frame_slave (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [spi_cfs_pkg::ByteW-1:0]      cfg_data,
    // event channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // rx_byte, reply_byte
    input  wire logic [spi_cfs_pkg::InDataW-1:0]    s_tdata,
    // command
    input  wire logic [spi_cfs_pkg::EventW-1:0]     s_tuser,
    // result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tx_byte, frame_command, frame_arg_one .. frame_arg_four, led_on, zero pad
    output logic [spi_cfs_pkg::OutDataW-1:0]        m_tdata,
    // tx_loaded, frame_valid
    output logic [spi_cfs_pkg::OutUserW-1:0]        m_tuser
);
    import spi_cfs_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_COMMAND   = 4'd1,
        PH_ARG_ONE   = 4'd2,
        PH_ARG_TWO   = 4'd3,
        PH_ARG_THREE = 4'd4,
        PH_ARG_FOUR  = 4'd5,
        PH_CHECKSUM  = 4'd6,
        PH_WAITING   = 4'd7,
        PH_REPLY     = 4'd8,
        PH_TX_START  = 4'd9,
        PH_TX_MARKER = 4'd10,
        PH_TX_REPLY  = 4'd11,
        PH_TX_SUM    = 4'd12
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   led_reg, led_next;
    byte_t  start_reg;
    byte_t  cmd_reg, cmd_next;
    byte_t  arg_reg [NumArgs];
    byte_t  arg_next [NumArgs];
    byte_t  sum_reg, sum_next;
    byte_t  chk_reg, chk_next;
    byte_t  reply_reg, reply_next;

    logic                    out_valid_reg;
    logic [OutDataW-1:0]     out_data_reg, out_data_next;
    logic [OutUserW-1:0]     out_user_reg, out_user_next;

    event_t ev;
    byte_t  rx;
    byte_t  rep;
    logic   accept;
    logic   tx_loaded;
    byte_t  tx_byte;
    logic   frame_valid;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign ev        = event_t'(s_tuser);
    assign rx        = s_tdata[ByteW-1:0];
    assign rep       = s_tdata[2*ByteW-1:ByteW];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        phase_next  = phase_reg;
        led_next    = led_reg;
        cmd_next    = cmd_reg;
        arg_next    = arg_reg;
        sum_next    = sum_reg;
        chk_next    = chk_reg;
        reply_next  = reply_reg;
        tx_loaded   = 1'b0;
        tx_byte     = TxIdleByte;
        frame_valid = 1'b0;

        case (ev)
            EV_RX_BYTE: begin
                tx_loaded = 1'b1;
                case (phase_reg)
                    PH_IDLE: begin
                        if (rx == start_reg) begin
                            phase_next = PH_COMMAND;
                        end
                    end
                    PH_COMMAND: begin
                        cmd_next   = rx;
                        sum_next   = rx;
                        phase_next = PH_ARG_ONE;
                    end
                    PH_ARG_ONE: begin
                        arg_next[0] = rx;
                        sum_next    = sum_reg + rx;
                        phase_next  = PH_ARG_TWO;
                    end
                    PH_ARG_TWO: begin
                        arg_next[1] = rx;
                        sum_next    = sum_reg + rx;
                        phase_next  = PH_ARG_THREE;
                    end
                    PH_ARG_THREE: begin
                        arg_next[2] = rx;
                        sum_next    = sum_reg + rx;
                        phase_next  = PH_ARG_FOUR;
                    end
                    PH_ARG_FOUR: begin
                        arg_next[3] = rx;
                        sum_next    = sum_reg + rx;
                        phase_next  = PH_CHECKSUM;
                    end
                    PH_CHECKSUM: begin
                        if (rx == sum_reg) begin
                            chk_next   = rx;
                            led_next   = 1'b1;
                            phase_next = PH_WAITING;
                        end else begin
                            led_next   = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WAITING, PH_REPLY: begin
                        phase_next = phase_reg;
                    end
                    PH_TX_START: begin
                        tx_byte    = start_reg;
                        phase_next = PH_TX_MARKER;
                    end
                    PH_TX_MARKER: begin
                        tx_byte    = TxMarkerByte;
                        phase_next = PH_TX_REPLY;
                    end
                    PH_TX_REPLY: begin
                        tx_byte    = reply_reg;
                        phase_next = PH_TX_SUM;
                    end
                    PH_TX_SUM: begin
                        tx_byte    = chk_reg + reply_reg;
                        phase_next = PH_IDLE;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            EV_DESELECT: begin
                phase_next = PH_IDLE;
            end
            EV_TAKE_FRAME: begin
                if (phase_reg == PH_WAITING) begin
                    frame_valid = 1'b1;
                    phase_next  = PH_REPLY;
                end
            end
            EV_SET_REPLY: begin
                if (phase_reg == PH_REPLY) begin
                    reply_next = rep;
                    phase_next = PH_TX_START;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        out_user_next = {frame_valid, tx_loaded};
        out_data_next = '0;
        out_data_next[ByteW-1:0] = tx_byte;
        if (frame_valid) begin
            out_data_next[2*ByteW-1:ByteW]   = cmd_reg;
            out_data_next[3*ByteW-1:2*ByteW] = arg_reg[0];
            out_data_next[4*ByteW-1:3*ByteW] = arg_reg[1];
            out_data_next[5*ByteW-1:4*ByteW] = arg_reg[2];
            out_data_next[6*ByteW-1:5*ByteW] = arg_reg[3];
        end
        out_data_next[6*ByteW] = led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            led_reg       <= 1'b0;
            start_reg     <= StartByteReset;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                start_reg <= cfg_data;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                led_reg       <= led_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= cmd_next;
            arg_reg      <= arg_next;
            sum_reg      <= sum_next;
            chk_reg      <= chk_next;
            reply_reg    <= reply_next;
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule : spi_command_frame_slave

`default_nettype wire
